### rtl/sha256_byte_stream_hasher_defines.svh
// Assertion helpers for the SHA-256 hasher.
`ifndef SHA256_BYTE_STREAM_HASHER_DEFINES_SVH
`define SHA256_BYTE_STREAM_HASHER_DEFINES_SVH

// Same-cycle implication, checked outside reset.
`define SHA_CHECK_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define SHA_CHECK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/sha256_pkg.sv
package sha256_pkg;

  typedef logic [31:0] word_t;
  // element 0 is a, element 7 is h
  typedef logic [7:0][31:0] hash_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       has_byte;
    logic       end_of_message;
  } in_req_t;

  typedef struct packed {
    logic [63:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;
  } out_req_t;

  // schedule window control
  typedef struct packed {
    logic  push;    // shift in an assembled message word
    word_t word;
    logic  expand;  // shift in the next expanded word
  } sched_ctl_t;

  // round unit control
  typedef struct packed {
    logic       load;   // copy hash into working vars
    logic       step;   // run one round
    logic [5:0] round;
  } round_ctl_t;

  localparam hash_t HashInit = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  function automatic word_t big_sigma0(input word_t x);
    big_sigma0 = {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    big_sigma1 = {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sigma0(input word_t x);
    small_sigma0 = {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sigma1(input word_t x);
    small_sigma1 = {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

  function automatic word_t round_k(input logic [5:0] idx);
    word_t k;
    case (idx)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = 32'h00000000;
    endcase
    round_k = k;
  endfunction

endpackage

### rtl/sha256_msg_sched.sv
// 16-word message window; word 0 feeds the current round.
module sha256_msg_sched import sha256_pkg::*; (
  input  logic       clk,
  input  sched_ctl_t ctl,
  output word_t      w_cur
);

  logic [15:0][31:0] win_r, win_nxt;
  word_t             w_exp;

  always_comb begin
    w_exp = small_sigma1(win_r[14]) + win_r[9] + small_sigma0(win_r[1]) + win_r[0];
    win_nxt = win_r;
    if (ctl.push || ctl.expand) begin
      for (int i = 0; i < 15; i++) begin
        win_nxt[i] = win_r[i+1];
      end
      win_nxt[15] = ctl.push ? ctl.word : w_exp;
    end
  end

  always_ff @(posedge clk) begin
    win_r <= win_nxt;
  end

  assign w_cur = win_r[0];

endmodule

### rtl/sha256_round_unit.sv
// Working variables a..h and the one shared compression round.
module sha256_round_unit import sha256_pkg::*; (
  input  logic       clk,
  input  round_ctl_t ctl,
  input  hash_t      hash_in,
  input  word_t      w_in,
  output hash_t      work
);

  hash_t work_r, work_nxt;
  word_t x1, x2, ch, maj;

  always_comb begin
    ch  = (work_r[4] & work_r[5]) ^ (~work_r[4] & work_r[6]);
    maj = (work_r[0] & work_r[1]) ^ (work_r[0] & work_r[2]) ^ (work_r[1] & work_r[2]);
    x1  = work_r[7] + big_sigma1(work_r[4]) + ch + round_k(ctl.round) + w_in;
    x2  = big_sigma0(work_r[0]) + maj;
    work_nxt = work_r;
    if (ctl.load) begin
      work_nxt = hash_in;
    end else if (ctl.step) begin
      work_nxt[7] = work_r[6];
      work_nxt[6] = work_r[5];
      work_nxt[5] = work_r[4];
      work_nxt[4] = work_r[3] + x1;
      work_nxt[3] = work_r[2];
      work_nxt[2] = work_r[1];
      work_nxt[1] = work_r[0];
      work_nxt[0] = x1 + x2;
    end
  end

  always_ff @(posedge clk) begin
    work_r <= work_nxt;
  end

  assign work = work_r;

endmodule

### rtl/sha256_byte_stream_hasher.sv
// SHA-256 (FIPS 180-4) over a byte stream. Each in_ request carries at most
// one message byte (has_byte) and may close the message (end_of_message); a
// request with only the end flag closes it without a byte, so an empty
// message is allowed. Ordinary byte requests are taken one per cycle. The
// request that completes a 64-byte block holds in_ready low while the block
// is compressed: 64 rounds through the single round unit, one round per
// cycle, then the hash update. Closing a message runs the padding (0x80,
// zeros, 64-bit big-endian bit count) at one byte per cycle through the same
// byte path, with one or two more block compressions, then offers the digest
// as four 64-bit out_ requests, word_index 0 to 3, first digest byte in the
// top bits, last_word on the fourth. in_ready stays low until the fourth
// word is taken; the initial hash values are then reloaded.
// The round unit sets the pace: a full block takes its 64 byte requests
// plus its compression with in_ready low. A close with f bytes left in the
// open block keeps in_ready low for 64 - f padding bytes and a compression,
// a further padded block and compression when f is 56 or more (and one more
// up front when the closing byte itself fills the block), then the digest.
`include "sha256_byte_stream_hasher_defines.svh"

module sha256_byte_stream_hasher import sha256_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_valid,
  output logic     in_ready,
  input  in_req_t  in_data,
  output logic     out_valid,
  input  logic     out_ready,
  output out_req_t out_data
);

  typedef enum logic [2:0] {
    S_IDLE, // waiting for a request
    S_COMP, // 64 compression rounds
    S_ADD,  // fold working vars into hash
    S_PAD,  // feeding padding bytes
    S_OUT   // offering digest words
  } state_t;

  state_t      state_r, state_nxt;
  logic [5:0]  fill_r, fill_nxt;        // bytes in current block
  logic [23:0] acc_r, acc_nxt;          // partial big-endian word
  logic [63:0] bitlen_r, bitlen_nxt;
  hash_t       hash_r, hash_nxt;
  logic [5:0]  rnd_r, rnd_nxt;
  logic        fin_pend_r, fin_pend_nxt;   // padding continues after compress
  logic        pad_first_r, pad_first_nxt; // next pad byte is 0x80
  logic        wrap_r, wrap_nxt;           // length needs an extra block
  logic        last_blk_r, last_blk_nxt;   // compressing the final block
  logic        out_valid_r, out_valid_nxt;
  out_req_t    out_data_r, out_data_nxt;
  logic [1:0]  out_idx_r, out_idx_nxt;

  logic        in_acc;
  logic        out_acc;
  logic        rnd_last;
  logic        push;
  logic [7:0]  push_byte;
  logic [7:0]  pad_byte;
  logic        blk_full;
  logic [1:0]  nidx;
  hash_t       work;
  hash_t       hsum;
  word_t       w_cur;
  sched_ctl_t  sched_ctl;
  round_ctl_t  round_ctl;

  assign in_ready  = (state_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign out_acc   = out_valid_r && out_ready;
  assign rnd_last  = (state_r == S_COMP) && (rnd_r == 6'd63);

  // Padding byte: 0x80 first, zeros up to the length field (or to the end of
  // the block when the length has to go in a fresh one), then the bit count
  // most significant byte first.
  always_comb begin
    if (pad_first_r) begin
      pad_byte = 8'h80;
    end else if ((fill_r < 6'd56) || wrap_r) begin
      pad_byte = 8'h00;
    end else begin
      pad_byte = bitlen_r[{~fill_r[2:0], 3'b000} +: 8];
    end
  end

  // One byte path shared by message and padding bytes.
  assign push      = (in_acc && in_data.has_byte) || (state_r == S_PAD);
  assign push_byte = (state_r == S_PAD) ? pad_byte : in_data.data_byte;
  assign blk_full  = push && (fill_r == 6'd63);

  always_comb begin
    sched_ctl.push   = push && (fill_r[1:0] == 2'b11);
    sched_ctl.word   = {acc_r, push_byte};
    sched_ctl.expand = (state_r == S_COMP);
    round_ctl.load   = blk_full;
    round_ctl.step   = (state_r == S_COMP);
    round_ctl.round  = rnd_r;
  end

  sha256_msg_sched u_sched (
    .clk   (clk),
    .ctl   (sched_ctl),
    .w_cur (w_cur)
  );

  sha256_round_unit u_round (
    .clk     (clk),
    .ctl     (round_ctl),
    .hash_in (hash_r),
    .w_in    (w_cur),
    .work    (work)
  );

  always_comb begin
    for (int i = 0; i < 8; i++) begin
      hsum[i] = hash_r[i] + work[i];
    end
  end

  assign nidx = out_idx_r + 2'd1;

  always_comb begin
    state_nxt     = state_r;
    fill_nxt      = fill_r;
    acc_nxt       = acc_r;
    bitlen_nxt    = bitlen_r;
    hash_nxt      = hash_r;
    rnd_nxt       = rnd_r;
    fin_pend_nxt  = fin_pend_r;
    pad_first_nxt = pad_first_r;
    wrap_nxt      = wrap_r;
    last_blk_nxt  = last_blk_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_idx_nxt   = out_idx_r;

    if (push) begin
      fill_nxt = fill_r + 6'd1;
      acc_nxt  = {acc_r[15:0], push_byte};
    end

    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          if (in_data.has_byte) begin
            bitlen_nxt = bitlen_r + 64'd8;
          end
          if (in_data.end_of_message) begin
            pad_first_nxt = 1'b1;
            wrap_nxt      = 1'b0;
          end
          if (blk_full) begin
            state_nxt    = S_COMP;
            rnd_nxt      = 6'd0;
            fin_pend_nxt = in_data.end_of_message;
          end else if (in_data.end_of_message) begin
            state_nxt = S_PAD;
          end
        end
      end
      S_PAD: begin
        pad_first_nxt = 1'b0;
        if (pad_first_r) begin
          wrap_nxt = (fill_r >= 6'd56);
        end
        if (blk_full) begin
          // a byte in the last slot closes the block; a length byte closes the final one
          state_nxt    = S_COMP;
          rnd_nxt      = 6'd0;
          wrap_nxt     = 1'b0;
          last_blk_nxt = !pad_first_r && !wrap_r;
          fin_pend_nxt = pad_first_r || wrap_r;
        end
      end
      S_COMP: begin
        rnd_nxt = rnd_r + 6'd1;
        if (rnd_r == 6'd63) begin
          state_nxt = S_ADD;
        end
      end
      S_ADD: begin
        hash_nxt = hsum;
        if (last_blk_r) begin
          state_nxt     = S_OUT;
          out_valid_nxt = 1'b1;
          out_idx_nxt   = 2'd0;
          out_data_nxt  = '{digest_word: {hsum[0], hsum[1]},
                            word_index:  2'd0,
                            last_word:   1'b0};
        end else if (fin_pend_r) begin
          state_nxt = S_PAD;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_OUT: begin
        if (out_acc) begin
          if (out_idx_r == 2'd3) begin
            // digest delivered: start a fresh message
            out_valid_nxt = 1'b0;
            state_nxt     = S_IDLE;
            hash_nxt      = HashInit;
            fill_nxt      = 6'd0;
            bitlen_nxt    = 64'd0;
            last_blk_nxt  = 1'b0;
            fin_pend_nxt  = 1'b0;
            wrap_nxt      = 1'b0;
            pad_first_nxt = 1'b0;
          end else begin
            out_idx_nxt  = nidx;
            out_data_nxt = '{digest_word: {hash_r[{nidx, 1'b0}], hash_r[{nidx, 1'b1}]},
                             word_index:  nidx,
                             last_word:   (nidx == 2'd3)};
          end
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      fill_r      <= 6'd0;
      bitlen_r    <= 64'd0;
      hash_r      <= HashInit;
      fin_pend_r  <= 1'b0;
      pad_first_r <= 1'b0;
      wrap_r      <= 1'b0;
      last_blk_r  <= 1'b0;
      out_valid_r <= 1'b0;
      out_idx_r   <= 2'd0;
    end else begin
      state_r     <= state_nxt;
      fill_r      <= fill_nxt;
      bitlen_r    <= bitlen_nxt;
      hash_r      <= hash_nxt;
      fin_pend_r  <= fin_pend_nxt;
      pad_first_r <= pad_first_nxt;
      wrap_r      <= wrap_nxt;
      last_blk_r  <= last_blk_nxt;
      out_valid_r <= out_valid_nxt;
      out_idx_r   <= out_idx_nxt;
    end
    acc_r      <= acc_nxt;
    rnd_r      <= rnd_nxt;
    out_data_r <= out_data_nxt;
  end

  // never take a request while a digest is pending
  `SHA_CHECK_SAME(a_ready_vs_out, in_ready, !out_valid, "request taken during digest output")
  // the 64th round is always followed by the hash update
  `SHA_CHECK_NEXT(a_round_end, rnd_last, state_r == S_ADD, "round count overrun")
  // the digest words follow one another without a gap in valid
  `SHA_CHECK_NEXT(a_word_follow, out_acc && !out_data.last_word, out_valid, "digest word missing")
  // after the final word the block is ready for the next message
  `SHA_CHECK_NEXT(a_ready_after, out_acc && out_data.last_word, in_ready && !out_valid, "still busy")

endmodule

### bench/tb.sv
`timescale 1ns / 1ps

import sha256_pkg::*;

// SHA-256 round constants, index 0 on the left.
localparam logic [0:63][31:0] ROUND_K = {
  32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
  32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
  32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
  32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
  32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
  32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
  32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
  32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
  32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
  32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
  32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
  32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
  32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
  32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
  32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
  32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
};

// Initial chaining value, word a on the left.
localparam logic [0:7][31:0] START_HASH = {
  32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
  32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19
};

// Digest predictor plus the queue of digest words still owed by the block.
class digest_scoreboard;
  bit [31:0] chain[8];
  bit [7:0]  block_bytes[64];
  int        fill;
  bit [63:0] msg_bits;
  out_req_t  owed_words[$];
  int        errors;
  int        words_checked;
  int        messages_closed;

  function new();
    errors = 0;
    words_checked = 0;
    messages_closed = 0;
    restart();
  endfunction

  function void restart();
    for (int i = 0; i < 8; i++) chain[i] = START_HASH[i];
    fill = 0;
    msg_bits = '0;
  endfunction

  function bit [31:0] rotr(bit [31:0] v, int n);
    return (v >> n) | (v << (32 - n));
  endfunction

  function void compress();
    bit [31:0] w[64];
    bit [31:0] a, b, c, d, e, f, g, h;
    bit [31:0] s0, s1, t1, t2;
    for (int t = 0; t < 16; t++)
      w[t] = {block_bytes[4*t], block_bytes[4*t+1], block_bytes[4*t+2], block_bytes[4*t+3]};
    for (int t = 16; t < 64; t++) begin
      s0 = rotr(w[t-15], 7) ^ rotr(w[t-15], 18) ^ (w[t-15] >> 3);
      s1 = rotr(w[t-2], 17) ^ rotr(w[t-2], 19) ^ (w[t-2] >> 10);
      w[t] = w[t-16] + s0 + w[t-7] + s1;
    end
    a = chain[0]; b = chain[1]; c = chain[2]; d = chain[3];
    e = chain[4]; f = chain[5]; g = chain[6]; h = chain[7];
    for (int t = 0; t < 64; t++) begin
      t1 = h + (rotr(e, 6) ^ rotr(e, 11) ^ rotr(e, 25)) + ((e & f) ^ (~e & g))
           + ROUND_K[t] + w[t];
      t2 = (rotr(a, 2) ^ rotr(a, 13) ^ rotr(a, 22)) + ((a & b) ^ (a & c) ^ (b & c));
      h = g; g = f; f = e; e = d + t1;
      d = c; c = b; b = a; a = t1 + t2;
    end
    chain[0] += a; chain[1] += b; chain[2] += c; chain[3] += d;
    chain[4] += e; chain[5] += f; chain[6] += g; chain[7] += h;
  endfunction

  function void close_message();
    out_req_t word;
    block_bytes[fill] = 8'h80;
    fill++;
    if (fill > 56) begin
      while (fill < 64) begin
        block_bytes[fill] = 8'h00;
        fill++;
      end
      compress();
      fill = 0;
    end
    while (fill < 56) begin
      block_bytes[fill] = 8'h00;
      fill++;
    end
    for (int k = 0; k < 8; k++) block_bytes[63-k] = msg_bits[8*k +: 8];
    compress();
    for (int k = 0; k < 4; k++) begin
      word.digest_word = {chain[2*k], chain[2*k+1]};
      word.word_index  = k[1:0];
      word.last_word   = (k == 3);
      owed_words = {owed_words, word};
    end
    messages_closed++;
    restart();
  endfunction

  function void note_request(in_req_t r);
    if (r.has_byte) begin
      block_bytes[fill] = r.data_byte;
      fill++;
      msg_bits += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (r.end_of_message) close_message();
  endfunction

  function void check_word(out_req_t got);
    out_req_t want;
    words_checked++;
    if (owed_words.size() == 0) begin
      $error("digest word with nothing owed: %h", got);
      errors++;
      return;
    end
    want = owed_words.pop_front();
    if (got.digest_word !== want.digest_word) begin
      $error("digest_word: expected %h, got %h", want.digest_word, got.digest_word);
      errors++;
    end
    if (got.word_index !== want.word_index) begin
      $error("word_index: expected %0d, got %0d", want.word_index, got.word_index);
      errors++;
    end
    if (got.last_word !== want.last_word) begin
      $error("last_word: expected %b, got %b", want.last_word, got.last_word);
      errors++;
    end
  endfunction
endclass

module tb;
  // Generous: well above the slowest legal run.
  localparam int CYCLE_LIMIT   = 400000;
  localparam int RANDOM_TARGET = 220;
  localparam int HOLD_CYCLES   = 400;
  localparam int IDLE_PCT      = 37;

  logic     clk;
  logic     rst_n;
  logic     in_valid;
  logic     in_ready;
  in_req_t  in_data;
  logic     out_valid;
  logic     out_ready;
  out_req_t out_data;

  digest_scoreboard sb;
  int cycle_count;
  int requests_sent;   // requests that carry a byte or an end flag
  bit steady;          // both sides run without idling while set
  bit hold_receiver;   // one-shot request for a long out_ready hold-off

  sha256_byte_stream_hasher dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic in_req_t make_req(logic [7:0] b, logic has, logic fin);
    in_req_t r;
    r.data_byte      = b;
    r.has_byte       = has;
    r.end_of_message = fin;
    return r;
  endfunction

  // Called on a falling edge; returns on the falling edge after acceptance.
  // in_valid is left high so the next call can swap the payload without a
  // low/high pair in one step; anyone who waits must lower it first.
  task automatic send_request(input in_req_t r);
    while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= r;
    do @(posedge clk); while (!in_ready);
    sb.note_request(r);
    if (r.has_byte || r.end_of_message) requests_sent++;
    @(negedge clk);
  endtask

  // Sender pause: nothing offered until every owed digest word is out.
  task automatic drain();
    in_valid <= 1'b0;
    while (sb.owed_words.size() != 0) @(negedge clk);
  endtask

  // One message of len random bytes. The end flag rides on the last byte
  // or on a flag-only request with junk in data_byte; requests with no
  // byte and no flag are sprinkled in as noise.
  task automatic send_message(input int len, input bit flag_on_byte);
    for (int i = 0; i < len; i++) begin
      if ($urandom_range(0, 99) < 8)
        send_request(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b0));
      send_request(make_req(8'($urandom_range(0, 255)), 1'b1,
                            flag_on_byte && (i == len - 1)));
    end
    if (!flag_on_byte || len == 0)
      send_request(make_req(8'($urandom_range(0, 255)), 1'b0, 1'b1));
  endtask

  // Mostly short messages; the rest sit on the padding boundaries
  // (55/56 bytes decide between one and two closing blocks, 64 fills a block).
  function automatic int pick_length();
    int edges[10] = '{54, 55, 56, 57, 62, 63, 64, 65, 119, 120};
    if ($urandom_range(0, 99) < 75) return $urandom_range(0, 10);
    return edges[$urandom_range(0, 9)];
  endfunction

  // Receiver: random out_ready, no idling while steady, and one long
  // hold-off that lets the block back up into its input.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_receiver) begin
        hold_receiver = 1'b0;
        out_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end else begin
        out_ready <= rst_n && (steady || $urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  // Digest words are checked at the edge that takes them.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) sb.check_word(out_data);
  end

  // Run limit.
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("timeout after %0d cycles", cycle_count);
    $display("** sha256_byte_stream_hasher: FAILED **");
    $finish;
  end

  initial begin
    int random_start;
    int msg_no;
    sb = new();
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    steady = 1'b0;
    hold_receiver = 1'b0;
    requests_sent = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: a noise request, empty messages (junk byte ignored), "abc"
    // with the flag on its last byte, single 0x00 and 0xff messages, and a
    // flag-only close after a byte and a noise request.
    send_request(make_req(8'hff, 1'b0, 1'b0));
    send_request(make_req(8'h00, 1'b0, 1'b1));
    send_request(make_req(8'hff, 1'b0, 1'b1));
    send_request(make_req(8'h61, 1'b1, 1'b0));
    send_request(make_req(8'h62, 1'b1, 1'b0));
    send_request(make_req(8'h63, 1'b1, 1'b1));
    send_request(make_req(8'h00, 1'b1, 1'b1));
    send_request(make_req(8'hff, 1'b1, 1'b1));
    send_request(make_req(8'h5a, 1'b1, 1'b0));
    send_request(make_req(8'ha5, 1'b0, 1'b0));
    send_request(make_req(8'h3c, 1'b0, 1'b1));
    drain();

    // Receiver holds off while the sender keeps offering short messages.
    hold_receiver = 1'b1;
    for (int i = 0; i < 4; i++) send_message(3, i[0]);
    drain();

    // Random messages; a stretch with no idling on either side and one
    // mid-run pause of the sender until everything owed has come out.
    random_start = requests_sent;
    msg_no = 0;
    while (requests_sent - random_start < RANDOM_TARGET) begin
      steady = (msg_no >= 2 && msg_no < 8);
      send_message(pick_length(), 1'($urandom_range(0, 1)));
      if (msg_no == 4) drain();
      msg_no++;
    end
    steady = 1'b0;
    drain();

    // Tail: any stray digest word shows up as one with nothing owed.
    repeat (200) @(posedge clk);

    $display("%0d requests sent, %0d messages hashed (empty, block-boundary and noise cases)",
             requests_sent, sb.messages_closed);
    $display("%0d digest words checked, %0d mismatches, %0d cycles",
             sb.words_checked, sb.errors, cycle_count);
    if (sb.errors == 0) begin
      $display("** sha256_byte_stream_hasher: PASSED **");
    end else begin
      $display("** sha256_byte_stream_hasher: FAILED **");
    end
    $finish;
  end
endmodule

### files.f
+incdir+rtl
rtl/sha256_pkg.sv
rtl/sha256_msg_sched.sv
rtl/sha256_round_unit.sv
rtl/sha256_byte_stream_hasher.sv
bench/tb.sv
